// ===== design/periodic_task_timer_table_macros.svh =====
// Assertion helpers shared by the timer table RTL.
`ifndef PERIODIC_TASK_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ptt_pkg.sv =====
`default_nettype none

package ptt_pkg;

  localparam int unsigned MaxTasksDef = 16;
  localparam int unsigned IdW         = 16;
  localparam int unsigned PerW        = 16;
  localparam int unsigned NowW        = 32;

  localparam logic [PerW-1:0] CountMax = {PerW{1'b1}};

  // operation codes
  localparam logic OpAdd  = 1'b0;
  localparam logic OpTick = 1'b1;

  // result kinds
  localparam logic KindAck    = 1'b0;
  localparam logic KindExpiry = 1'b1;

  typedef enum logic {
    StIdle,
    StWalk
  } ptt_state_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [PerW-1:0] period;
    logic [PerW-1:0] count;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/ptt_cell.sv =====
`default_nettype none

module ptt_cell import ptt_pkg::*; (
  input  wire        clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire entry_t     load_i,
  input  wire entry_t     shift_i,
  output entry_t     entry_o,
  output entry_t     upd_o,
  output logic       fire_o
);

  entry_t          ent_q;
  logic [PerW-1:0] inc;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ent_q <= load_i;
    end else if (ctrl_i.shift) begin
      ent_q <= shift_i;
    end
  end

  // saturating increment, then compare against a nonzero period
  always_comb begin
    inc    = (ent_q.count == CountMax) ? ent_q.count : ent_q.count + PerW'(1);
    fire_o = (ent_q.period != '0) && (inc == ent_q.period);
    upd_o.id     = ent_q.id;
    upd_o.period = ent_q.period;
    upd_o.count  = fire_o ? '0 : inc;
  end

  assign entry_o = ent_q;

endmodule

`default_nettype wire

// ===== design/periodic_task_timer_table.sv =====
// An add answers in the cycle after its transfer; a tick's expiries leave through the
//   result register as the ring walk reaches each firing task.
// Adds are taken one per cycle while idle and the result side is ready; a tick walks the
//   full ring, stalling while an expiry waits on the result side, before the next item.
// Reset: rst_ni asynchronous, active low; clears fill count, tick number, FSM and
//   output valid. Task cells hold no reset and are written before first use.
`default_nettype none

`include "periodic_task_timer_table_macros.svh"

module periodic_task_timer_table import ptt_pkg::*; #(
  parameter int unsigned MaxTasks = MaxTasksDef
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  wire             operation_i,
  input  wire  [IdW-1:0]  task_id_i,
  input  wire  [PerW-1:0] period_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output logic            kind_o,
  output logic [IdW-1:0]  expired_id_o,
  output logic            accepted_o,
  output logic [NowW-1:0] now_o,
  output logic            last_o
);

  localparam int unsigned StepW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW  = $clog2(MaxTasks + 1);
  localparam int unsigned SumW  = $clog2(2 * MaxTasks + 1);
  localparam logic [StepW-1:0] LastStep = StepW'(MaxTasks - 1);

  ptt_state_e       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [NowW-1:0]  tick_q, tick_d;

  logic            out_valid_q, out_valid_d;
  logic            kind_q, kind_d;
  logic [IdW-1:0]  id_q, id_d;
  logic            acc_q, acc_d;
  logic [NowW-1:0] now_q, now_d;
  logic            last_q, last_d;

  entry_t          ent_v [MaxTasks];
  entry_t          upd_v [MaxTasks];
  logic [MaxTasks-1:0] fire_v;
  logic [MaxTasks-1:0] live_v;
  logic [MaxTasks-1:0] later_v;
  cell_ctrl_t      ctrl_v [MaxTasks];
  entry_t          load_entry;
  entry_t          tail_in;

  logic in_xfer, is_add, tbl_free, out_free;
  logic head_live, head_fire, stall, advance, emit_exp, later_fire;

  // ------------------------------------------------------------------
  // Handshake. An add answers at once, so the input waits for a free
  // output slot; a tick walks the whole ring before the next item.
  // ------------------------------------------------------------------
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_add     = in_xfer && (operation_i == OpAdd);
  assign tbl_free   = used_q < CntW'(MaxTasks);

  assign load_entry.id     = task_id_i;
  assign load_entry.period = period_i;
  assign load_entry.count  = '0;

  // ------------------------------------------------------------------
  // Cell ring. During a walk every cell hands its entry to its lower
  // neighbor; cell 0 is the head, its updated entry re-enters at the
  // tail. After MaxTasks steps every entry is back in its own cell, so
  // cell j always holds task j while idle. At step s, cell j holds task
  // j+s, which still awaits its turn when j+s is below the fill count.
  // ------------------------------------------------------------------
  assign head_live = CntW'(step_q) < used_q;
  assign head_fire = fire_v[0] && head_live;
  assign tail_in   = head_live ? upd_v[0] : ent_v[0];

  // hold the ring while an expiry cannot be handed to the output slot
  assign stall    = head_fire && !out_free;
  assign advance  = (state_q == StWalk) && !stall;
  assign emit_exp = (state_q == StWalk) && head_fire && out_free;

  for (genvar j = 0; j < MaxTasks; j++) begin : g_cell
    entry_t shift_in;

    if (j == MaxTasks - 1) begin : g_tail
      assign shift_in = tail_in;
    end else begin : g_body
      assign shift_in = ent_v[j+1];
    end

    assign ctrl_v[j].shift = advance;
    assign ctrl_v[j].load  = is_add && tbl_free && (CntW'(j) == used_q);
    assign live_v[j]       = (SumW'(j) + SumW'(step_q)) < SumW'(used_q);
    assign later_v[j]      = (j != 0);

    ptt_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_v[j]),
      .load_i  (load_entry),
      .shift_i (shift_in),
      .entry_o (ent_v[j]),
      .upd_o   (upd_v[j]),
      .fire_o  (fire_v[j])
    );
  end

  // the head's expiry is the tick's last one when no later live task fires
  assign later_fire = |(fire_v & live_v & later_v);

  // ------------------------------------------------------------------
  // Next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_xfer && (operation_i == OpTick)) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (advance && (step_q == LastStep)) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // ------------------------------------------------------------------
  // Counters and result slot
  // ------------------------------------------------------------------
  always_comb begin
    step_d      = step_q;
    used_d      = used_q;
    tick_d      = tick_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    id_d        = id_q;
    acc_d       = acc_q;
    now_d       = now_q;
    last_d      = last_q;

    if (is_add) begin
      if (tbl_free) begin
        used_d = used_q + CntW'(1);
      end
      out_valid_d = 1'b1;
      kind_d      = KindAck;
      id_d        = task_id_i;
      acc_d       = tbl_free;
      now_d       = '0;
      last_d      = 1'b1;
    end

    if (emit_exp) begin
      out_valid_d = 1'b1;
      kind_d      = KindExpiry;
      id_d        = ent_v[0].id;
      acc_d       = 1'b0;
      now_d       = tick_q;
      last_d      = !later_fire;
    end

    if (advance) begin
      if (step_q == LastStep) begin
        step_d = '0;
        tick_d = tick_q + NowW'(1);
      end else begin
        step_d = step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      used_q      <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      used_q      <= used_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload of the result slot
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    id_q   <= id_d;
    acc_q  <= acc_d;
    now_q  <= now_d;
    last_q <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign expired_id_o = id_q;
  assign accepted_o   = acc_q;
  assign now_o        = now_q;
  assign last_o       = last_q;

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  `PTT_ASSERT_NEXT(a_full_add_keeps_count, clk_i, rst_ni, is_add && !tbl_free,
    used_q == $past(used_q), "rejected add changed the fill count")

  `PTT_ASSERT_NEXT(a_walk_end_ticks, clk_i, rst_ni,
    advance && (step_q == LastStep),
    (tick_q == $past(tick_q) + NowW'(1)) && (step_q == '0),
    "tick number did not advance at end of walk")

  `PTT_ASSERT_NOW(a_idle_ring_home, clk_i, rst_ni, state_q == StIdle,
    step_q == '0, "ring left rotated while idle")

endmodule

`default_nettype wire
